/* design/mavs_pkg.sv */
`timescale 1ns / 1ps

package mavs_pkg;

    // window geometry
    localparam int ADDR_BITS   = 10;
    localparam int DEPTH       = 1 << ADDR_BITS;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 26;
    localparam int VOLT_BITS   = 16;

    // voltage scaling: sum * 187 / 167731
    localparam int MUL_BITS    = 8;
    localparam int DIV_BITS    = 18;
    localparam int PROD_BITS   = SUM_BITS + MUL_BITS;
    localparam int HI_SHIFT    = 16;
    localparam int HI_BITS     = PROD_BITS - HI_SHIFT;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_BITS  = 27;
    localparam int EST_BITS    = HI_BITS + RECIP_BITS;
    localparam int QEST_BITS   = EST_BITS - RECIP_SHIFT;
    localparam int QPROD_BITS  = QEST_BITS + DIV_BITS;

    localparam logic [MUL_BITS-1:0]  VOLT_MUL = MUL_BITS'(187);
    localparam logic [DIV_BITS-1:0]  VOLT_DIV = DIV_BITS'(167731);
    localparam logic [VOLT_BITS-1:0] VOLT_MAX = VOLT_BITS'(16'hFFFF);

    // floor(2^44 / 167731), quotient estimate low by at most one
    localparam logic [RECIP_BITS-1:0] VOLT_RECIP =
        RECIP_BITS'((64'd1 << (HI_SHIFT + RECIP_SHIFT)) / 64'd167731);

endpackage

/* design/mavs_scaler.sv */
`timescale 1ns / 1ps

module mavs_scaler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               total_valid,
    output logic                               total_stall,
    input  logic [mavs_pkg::SUM_BITS-1:0]      window_total,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [mavs_pkg::VOLT_BITS-1:0]     voltage_mv,
    output logic [mavs_pkg::SUM_BITS-1:0]      window_sum
);

    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    logic                              s3_valid_reg;
    logic                              s4_valid_reg;
    logic                              out_valid_reg;

    logic [mavs_pkg::SUM_BITS-1:0]     s1_sum_reg;
    logic [mavs_pkg::SUM_BITS-1:0]     s2_sum_reg;
    logic [mavs_pkg::SUM_BITS-1:0]     s3_sum_reg;
    logic [mavs_pkg::SUM_BITS-1:0]     s4_sum_reg;
    logic [mavs_pkg::PROD_BITS-1:0]    s2_p_reg;
    logic [mavs_pkg::PROD_BITS-1:0]    s3_p_reg;
    logic [mavs_pkg::PROD_BITS-1:0]    s4_p_reg;
    logic [mavs_pkg::QEST_BITS-1:0]    s3_qest_reg;
    logic [mavs_pkg::QEST_BITS-1:0]    s4_qest_reg;
    logic [mavs_pkg::PROD_BITS-1:0]    s4_back_reg;
    logic [mavs_pkg::VOLT_BITS-1:0]    volt_reg;
    logic [mavs_pkg::SUM_BITS-1:0]     sum_out_reg;

    logic                              out_ready;
    logic                              s4_ready;
    logic                              s3_ready;
    logic                              s2_ready;
    logic                              s1_ready;

    logic [mavs_pkg::PROD_BITS-1:0]    p_next;
    logic [mavs_pkg::EST_BITS-1:0]     est_full;
    logic [mavs_pkg::QEST_BITS-1:0]    qest_next;
    logic [mavs_pkg::QPROD_BITS-1:0]   back_full;
    logic [mavs_pkg::PROD_BITS-1:0]    back_next;
    logic [mavs_pkg::PROD_BITS-1:0]    rem;
    logic                              bump;
    logic [mavs_pkg::QEST_BITS-1:0]    quot;
    logic [mavs_pkg::VOLT_BITS-1:0]    volt_next;

    // per-stage ready so bubbles collapse
    assign out_ready   = !out_valid_reg || !result_stall;
    assign s4_ready    = !s4_valid_reg || out_ready;
    assign s3_ready    = !s3_valid_reg || s4_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign total_stall = !s1_ready;

    assign p_next    = mavs_pkg::PROD_BITS'(s1_sum_reg)
                     * mavs_pkg::PROD_BITS'(mavs_pkg::VOLT_MUL);
    assign est_full  = mavs_pkg::EST_BITS'(s2_p_reg[mavs_pkg::PROD_BITS-1:mavs_pkg::HI_SHIFT])
                     * mavs_pkg::EST_BITS'(mavs_pkg::VOLT_RECIP);
    assign qest_next = est_full[mavs_pkg::RECIP_SHIFT +: mavs_pkg::QEST_BITS];
    assign back_full = mavs_pkg::QPROD_BITS'(s3_qest_reg)
                     * mavs_pkg::QPROD_BITS'(mavs_pkg::VOLT_DIV);
    assign back_next = back_full[mavs_pkg::PROD_BITS-1:0];

    // one correction step, then saturate
    assign rem       = s4_p_reg - s4_back_reg;
    assign bump      = rem >= mavs_pkg::PROD_BITS'(mavs_pkg::VOLT_DIV);
    assign quot      = s4_qest_reg + mavs_pkg::QEST_BITS'(bump);
    assign volt_next = (quot > mavs_pkg::QEST_BITS'(mavs_pkg::VOLT_MAX))
                     ? mavs_pkg::VOLT_MAX : quot[mavs_pkg::VOLT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= total_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && total_valid)
        begin
            s1_sum_reg <= window_total;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg <= s1_sum_reg;
            s2_p_reg   <= p_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sum_reg  <= s2_sum_reg;
            s3_p_reg    <= s2_p_reg;
            s3_qest_reg <= qest_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_sum_reg  <= s3_sum_reg;
            s4_p_reg    <= s3_p_reg;
            s4_qest_reg <= s3_qest_reg;
            s4_back_reg <= back_next;
        end
        if (out_ready && s4_valid_reg)
        begin
            volt_reg    <= volt_next;
            sum_out_reg <= s4_sum_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign voltage_mv   = volt_reg;
    assign window_sum   = sum_out_reg;

`ifndef SYNTH
    a_est_not_high: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_p_reg >= s4_back_reg)
        else $error("quotient estimate above true quotient");

    a_est_one_low: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> rem < (mavs_pkg::PROD_BITS'(mavs_pkg::VOLT_DIV) << 1))
        else $error("quotient estimate more than one below");

    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && window_sum == '0) |-> voltage_mv == '0)
        else $error("nonzero voltage for empty sum");
`endif

endmodule

/* design/moving_average_voltage_scaler.sv */
`timescale 1ns / 1ps

// channel   signals                               payload
// sample    sample_valid / sample_stall           sample
// result    result_valid / result_stall           voltage_mv, window_sum
//
// one sample per cycle sustained unless result_stall backs up to sample_stall; the ring
// store is read and written at the same slot in the accept cycle, read-first, so each slot sees one access a cycle
// an accepted sample passes the update stage, scaler stages s1 to s4 and the
// output register; reset clears slot pointer, running total and priming flags;
// the store itself is not cleared, unwritten slots stand in as the priming sample
// a stalled result holds its stage; earlier stages keep filling until full

module moving_average_voltage_scaler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [15:0]                        sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [mavs_pkg::VOLT_BITS-1:0]     voltage_mv,
    output logic [mavs_pkg::SUM_BITS-1:0]      window_sum
);

    logic [mavs_pkg::SAMPLE_BITS-1:0]  store_mem [mavs_pkg::DEPTH];
    logic [mavs_pkg::SAMPLE_BITS-1:0]  rd_reg;

    logic [mavs_pkg::ADDR_BITS-1:0]    slot_reg;
    logic                              primed_reg;
    logic                              wrapped_reg;
    logic [mavs_pkg::SAMPLE_BITS-1:0]  fill_reg;
    logic [mavs_pkg::SUM_BITS-1:0]     total_reg;

    logic                              b_valid_reg;
    logic [mavs_pkg::SAMPLE_BITS-1:0]  b_value_reg;
    logic                              b_first_reg;
    logic                              b_use_fill_reg;

    logic                              accept;
    logic                              b_ready;
    logic                              total_stall;
    logic [mavs_pkg::SAMPLE_BITS-1:0]  value;
    logic [mavs_pkg::SAMPLE_BITS-1:0]  oldest;
    logic [mavs_pkg::SUM_BITS-1:0]     total_next;

    assign value        = sample[mavs_pkg::SAMPLE_BITS-1:0];
    assign b_ready      = !b_valid_reg || !total_stall;
    assign sample_stall = !b_ready;
    assign accept       = sample_valid && b_ready;

    assign oldest     = b_use_fill_reg ? fill_reg : rd_reg;
    assign total_next = b_first_reg
                      ? (mavs_pkg::SUM_BITS'(b_value_reg) << mavs_pkg::ADDR_BITS)
                      : total_reg - mavs_pkg::SUM_BITS'(oldest)
                        + mavs_pkg::SUM_BITS'(b_value_reg);

    // ring store, read-first at the write slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg              <= store_mem[slot_reg];
            store_mem[slot_reg] <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            primed_reg  <= 1'b0;
            wrapped_reg <= 1'b0;
            fill_reg    <= '0;
            total_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= sample_valid;
            end
            if (accept)
            begin
                slot_reg   <= slot_reg + mavs_pkg::ADDR_BITS'(1);
                primed_reg <= 1'b1;
                if (slot_reg == '1)
                begin
                    wrapped_reg <= 1'b1;
                end
                if (!primed_reg)
                begin
                    fill_reg <= value;
                end
            end
            if (b_valid_reg && !total_stall)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_value_reg    <= value;
            b_first_reg    <= !primed_reg;
            b_use_fill_reg <= primed_reg && !wrapped_reg;
        end
    end

    mavs_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .total_valid  (b_valid_reg),
        .total_stall  (total_stall),
        .window_total (total_next),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .voltage_mv   (voltage_mv),
        .window_sum   (window_sum)
    );

`ifndef SYNTH
    a_unprimed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (slot_reg == '0 && !wrapped_reg))
        else $error("slot moved before priming");

    a_wrap_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag cleared");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted transaction lost before update stage");
`endif

endmodule

/* tb/tb_moving_average_voltage_scaler.sv */
`timescale 1ns / 1ps

module tb_moving_average_voltage_scaler;

    typedef struct packed {
        logic [mavs_pkg::VOLT_BITS-1:0] volt;
        logic [mavs_pkg::SUM_BITS-1:0]  sum;
    } reading_t;

    typedef struct packed {
        logic [mavs_pkg::SAMPLE_BITS-1:0] value;
        bit                               typed;
        logic [mavs_pkg::VOLT_BITS-1:0]   volt;
        logic [mavs_pkg::SUM_BITS-1:0]    sum;
    } stim_row_t;

    typedef enum int {BAND_ANY, BAND_HIGH, BAND_LOW, BAND_MID} band_t;

    localparam int N_DIR          = 16;
    localparam int N_PHASES       = 4;
    localparam int RAND_PER_PHASE = 146;
    localparam int BAND_RUN       = 50;
    localparam logic [mavs_pkg::SUM_BITS-1:0] FULL_SUM =
        mavs_pkg::SUM_BITS'(65535 * mavs_pkg::DEPTH);

    // priming with the top code saturates the voltage at once
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{16'hFFFF, 1'b1, mavs_pkg::VOLT_MAX, FULL_SUM},
        '{16'hFFFF, 1'b1, mavs_pkg::VOLT_MAX, FULL_SUM},
        '{16'h0000, 1'b0, '0, '0},
        '{16'h0000, 1'b0, '0, '0},
        '{16'h0001, 1'b0, '0, '0},
        '{16'h8000, 1'b0, '0, '0},
        '{16'h7FFF, 1'b0, '0, '0},
        '{16'hAAAA, 1'b0, '0, '0},
        '{16'h5555, 1'b0, '0, '0},
        '{16'h00FF, 1'b0, '0, '0},
        '{16'hFF00, 1'b0, '0, '0},
        '{16'hFFFE, 1'b0, '0, '0},
        '{16'h0F0F, 1'b0, '0, '0},
        '{16'hF0F0, 1'b0, '0, '0},
        '{16'h1234, 1'b0, '0, '0},
        '{16'hFFFF, 1'b0, '0, '0}
    };

    localparam int IDLE_PCT  [N_PHASES] = '{0, 70, 0, 19};
    localparam int STALL_PCT [N_PHASES] = '{0, 0, 70, 19};

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             sample_valid = 1'b0;
    logic                             sample_stall;
    logic [15:0]                      sample       = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    logic [mavs_pkg::VOLT_BITS-1:0]   voltage_mv;
    logic [mavs_pkg::SUM_BITS-1:0]    window_sum;

    int                               idle_pct  = 0;
    int                               stall_pct = 0;
    int                               err_count = 0;

    bit                               row_typed = 1'b0;
    logic [mavs_pkg::VOLT_BITS-1:0]   row_volt  = '0;
    logic [mavs_pkg::SUM_BITS-1:0]    row_sum   = '0;

    reading_t                         pending_readings [$];

    // window state mirrored from the block
    logic [mavs_pkg::SAMPLE_BITS-1:0] win_store [mavs_pkg::DEPTH];
    logic [mavs_pkg::ADDR_BITS-1:0]   win_slot    = '0;
    logic [31:0]                      win_total   = '0;
    bit                               win_primed  = 1'b0;
    bit                               win_wrapped = 1'b0;
    logic [mavs_pkg::SAMPLE_BITS-1:0] win_fill    = '0;

    moving_average_voltage_scaler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .voltage_mv   (voltage_mv),
        .window_sum   (window_sum)
    );

    always #2 clk = ~clk;

    function automatic reading_t window_update(
        input logic [mavs_pkg::SAMPLE_BITS-1:0] value
    );
        reading_t                         r;
        logic [63:0]                      scaled;
        logic [mavs_pkg::SAMPLE_BITS-1:0] oldest;
        if (!win_primed)
        begin
            win_primed = 1'b1;
            win_fill   = value;
            win_total  = 32'(value) * mavs_pkg::DEPTH;
        end
        else
        begin
            oldest    = win_wrapped ? win_store[win_slot] : win_fill;
            win_total = win_total - 32'(oldest) + 32'(value);
        end
        win_store[win_slot] = value;
        win_slot = win_slot + 1'b1;
        if (win_slot == '0)
            win_wrapped = 1'b1;
        scaled = (64'(win_total) * 64'(mavs_pkg::VOLT_MUL)) / 64'(mavs_pkg::VOLT_DIV);
        r.volt = (scaled > 64'(mavs_pkg::VOLT_MAX))
               ? mavs_pkg::VOLT_MAX : scaled[mavs_pkg::VOLT_BITS-1:0];
        r.sum  = win_total[mavs_pkg::SUM_BITS-1:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_sample(input band_t band);
        case (band)
            BAND_HIGH: return 16'($urandom_range(16'hFFFF, 16'hE000));
            BAND_LOW:  return 16'($urandom_range(16'h1FFF, 16'h0000));
            BAND_MID:  return 16'($urandom_range(16'hA000, 16'h6000));
            default:   return 16'($urandom_range(16'hFFFF, 16'h0000));
        endcase
    endfunction

    // one transaction per call, held until accepted
    task automatic send_sample(input stim_row_t row);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= row.value;
        row_typed     = row.typed;
        row_volt      = row.volt;
        row_sum       = row.sum;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                want = window_update(sample);
                if (row_typed)
                begin
                    want.volt = row_volt;
                    want.sum  = row_sum;
                end
                pending_readings.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t: unexpected result voltage_mv %0d window_sum %0d",
                             $time, voltage_mv, window_sum);
                    err_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (voltage_mv !== want.volt)
                    begin
                        $display("%0t: voltage_mv expected %0d, got %0d",
                                 $time, want.volt, voltage_mv);
                        err_count++;
                    end
                    if (window_sum !== want.sum)
                    begin
                        $display("%0t: window_sum expected %0d, got %0d",
                                 $time, want.sum, window_sum);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        band_t     band;
        band = BAND_ANY;
        row  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == 0)
                for (int i = 0; i < N_DIR; i++)
                    send_sample(DIR_ROWS[i]);
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                if (k % BAND_RUN == 0)
                    band = band_t'($urandom_range(3));
                row.value = pick_sample(band);
                row.typed = 1'b0;
                send_sample(row);
            end
        end
        sample_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
